FILE: design/keyword_identifier_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// keyword_identifier_tokenizer_assert.svh
// Assertion macros for the tokenizer; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_IDENTIFIER_TOKENIZER_ASSERT_SVH
`define KEYWORD_IDENTIFIER_TOKENIZER_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define KIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tokenizer assertion failed");
// Condition must never be seen out of reset.
`define KIT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tokenizer forbidden condition seen");
`else
`define KIT_ASSERT(lbl, prop)
`define KIT_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: design/kit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kit_pkg
// Types, constants and character-class helpers for the tokenizer.
// ----------------------------------------------------------------------------
package kit_pkg;

  localparam int MAX_LEXEME_LEN = 255;
  localparam int LEN_W          = $clog2(MAX_LEXEME_LEN + 1);
  localparam int KW_SLOTS       = 6;
  localparam int NUM_KW_REGS    = 6;
  localparam int KW_USED        = (KW_SLOTS < NUM_KW_REGS) ? KW_SLOTS : NUM_KW_REGS;
  localparam int KW_W           = 48;
  localparam int PREFIX_CHARS   = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int SLOT_W         = 3;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = 2;
  localparam int FIFO_CNT_W     = 3;

  // "if", "else", "while", "int", "double", "string", first char in low byte
  localparam logic [KW_W-1:0] KW_RESET [NUM_KW_REGS] = '{
    48'd26217,
    48'd1702063205,
    48'd435610544247,
    48'd7630441,
    48'd111516182736740,
    48'd113723913172083
  };

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [1:0] {
    TOK_IDENT   = 2'd0,
    TOK_KEYWORD = 2'd1,
    TOK_LITERAL = 2'd2,
    TOK_PUNCT   = 2'd3
  } tok_class_t;

  typedef enum logic {
    KIND_CHAR  = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_t;

  typedef struct packed {
    tok_class_t        cls;
    logic [7:0]        len;
    logic [7:0]        punct;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // position of the highest nonzero byte plus one
  function automatic logic [2:0] word_len(input logic [KW_W-1:0] w);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < PREFIX_CHARS; i++) begin
      if (w[8*i +: 8] != 8'h00) n = 3'(i + 1);
    end
    return n;
  endfunction

endpackage

FILE: design/keyword_identifier_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_identifier_tokenizer
// Character-stream tokenizer: identifiers, keywords, literals, punctuation.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one character or end-of-line flush
//    per transfer. One item is taken every cycle while in_stall is low.
//  - Result channel (out_valid / out_stall): zero, one or two tokens per item,
//    in order; last_of_run marks the final token of an item.
//  - A token is written to the result queue when its item transfers.
//  - Throughput: one item per cycle while in_stall is low; one token drains
//    a cycle while out_stall is low, so a delimiter that closes a lexeme and
//    is itself punctuation yields two tokens, absorbed by a 4-entry result queue.
//  - in_stall rises when the queue holds more than two tokens, so that an item
//    always has room for both of its results. It depends only on registers.
//  - A stalled receiver holds the head token steady; the queue fills and then
//    stalls the input side.
//  - Reset (rst_n low, synchronous) empties the queue, clears the pending
//    lexeme and reloads the six keyword registers with their defaults.
//  - cfg_we writes keyword register cfg_index; indexes above five are ignored.
// ----------------------------------------------------------------------------
`include "keyword_identifier_tokenizer_assert.svh"

module keyword_identifier_tokenizer
  import kit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [7:0]           in_char_code,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_token_class,
  output logic [7:0]           out_token_length,
  output logic [7:0]           out_punct_char,
  output logic [SLOT_W-1:0]    out_keyword_slot,
  output logic                 out_last_of_run,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KW_W-1:0]      cfg_wdata
);

  logic [KW_W-1:0]       kw_r [NUM_KW_REGS];

  logic [LEN_W-1:0]      lex_len_r, lex_len_nxt;
  logic                  lex_digit_r, lex_digit_nxt;
  logic [KW_W-1:0]       lex_prefix_r, lex_prefix_nxt;

  result_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  logic                  in_xfer;
  logic                  out_xfer;
  logic                  lex_pending;
  logic                  kw_hit;
  logic [SLOT_W-1:0]     kw_slot;
  logic [7:0]            len_sat;
  result_t               lex_res;
  result_t               punct_res;
  result_t               res0, res1;
  logic [1:0]            n_push;
  result_t               head;

  assign in_xfer     = in_valid && !in_stall;
  assign out_xfer    = out_valid && !out_stall;
  assign lex_pending = (lex_len_r != '0);

  // room for two tokens is needed before an item is taken
  assign in_stall  = (count_r > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (count_r != '0);

  // ---------------- keyword match, lowest slot wins ----------------
  always_comb begin
    kw_hit  = 1'b0;
    kw_slot = '0;
    for (int s = KW_USED - 1; s >= 0; s--) begin
      if ((word_len(kw_r[s]) != 3'd0) &&
          (LEN_W'(word_len(kw_r[s])) == lex_len_r) &&
          (kw_r[s] == lex_prefix_r)) begin
        kw_hit  = 1'b1;
        kw_slot = SLOT_W'(s);
      end
    end
  end

  assign len_sat = (32'(lex_len_r) > 32'd255) ? 8'hFF : 8'(lex_len_r);

  always_comb begin
    lex_res       = '0;
    lex_res.len   = len_sat;
    lex_res.punct = 8'h00;
    if (lex_digit_r) begin
      lex_res.cls = TOK_LITERAL;
    end else if (kw_hit) begin
      lex_res.cls  = TOK_KEYWORD;
      lex_res.slot = kw_slot;
    end else begin
      lex_res.cls = TOK_IDENT;
    end
    punct_res       = '0;
    punct_res.cls   = TOK_PUNCT;
    punct_res.len   = 8'd1;
    punct_res.punct = in_char_code;
  end

  // ---------------- per-item work ----------------
  always_comb begin
    lex_len_nxt    = lex_len_r;
    lex_digit_nxt  = lex_digit_r;
    lex_prefix_nxt = lex_prefix_r;
    res0           = lex_res;
    res1           = punct_res;
    n_push         = 2'd0;

    if (in_kind == KIND_FLUSH) begin
      if (lex_pending) begin
        n_push      = 2'd1;
        res0.last   = 1'b1;
      end
      lex_len_nxt    = '0;
      lex_digit_nxt  = 1'b0;
      lex_prefix_nxt = '0;
    end else if (is_word(in_char_code)) begin
      if (!lex_pending) lex_digit_nxt = is_digit(in_char_code);
      for (int i = 0; i < PREFIX_CHARS; i++) begin
        if (lex_len_r == LEN_W'(i)) lex_prefix_nxt[8*i +: 8] = in_char_code;
      end
      if (lex_len_r < LEN_W'(MAX_LEXEME_LEN)) lex_len_nxt = lex_len_r + 1'b1;
    end else begin
      lex_len_nxt    = '0;
      lex_digit_nxt  = 1'b0;
      lex_prefix_nxt = '0;
      if (lex_pending) begin
        if (is_space(in_char_code)) begin
          n_push    = 2'd1;
          res0.last = 1'b1;
        end else begin
          n_push    = 2'd2;
          res1.last = 1'b1;
        end
      end else if (!is_space(in_char_code)) begin
        n_push    = 2'd1;
        res0      = punct_res;
        res0.last = 1'b1;
      end
    end

    if (!in_xfer) begin
      lex_len_nxt    = lex_len_r;
      lex_digit_nxt  = lex_digit_r;
      lex_prefix_nxt = lex_prefix_r;
      n_push         = 2'd0;
    end
  end

  // ---------------- result queue control ----------------
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(out_xfer);
    count_nxt  = count_r + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_len_r    <= '0;
      lex_digit_r  <= 1'b0;
      lex_prefix_r <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      lex_len_r    <= lex_len_nxt;
      lex_digit_r  <= lex_digit_nxt;
      lex_prefix_r <= lex_prefix_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (n_push == 2'd2) fifo_r[wr_ptr_r + 1'b1] <= res1;
  end

  // ---------------- keyword registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KW_REGS; k++) kw_r[k] <= KW_RESET[k];
    end else if (cfg_we && (32'(cfg_index) < NUM_KW_REGS)) begin
      kw_r[cfg_index[$clog2(NUM_KW_REGS)-1:0]] <= cfg_wdata;
    end
  end

  assign head             = fifo_r[rd_ptr_r];
  assign out_token_class  = head.cls;
  assign out_token_length = head.len;
  assign out_punct_char   = head.punct;
  assign out_keyword_slot = head.slot;
  assign out_last_of_run  = head.last;

  // ---------------- checks ----------------
  `KIT_ASSERT(a_queue_bound, count_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `KIT_ASSERT(a_punct_last, out_valid && (out_token_class == TOK_PUNCT) |-> out_last_of_run)
  `KIT_ASSERT(a_lex_no_char, out_valid && (out_token_class != TOK_PUNCT) |-> out_punct_char == 8'h00)
  `KIT_ASSERT(a_slot_only_kw, out_valid && (out_token_class != TOK_KEYWORD) |-> out_keyword_slot == '0)
  `KIT_ASSERT(a_idle_lex_clear, (lex_len_r == '0) |-> (lex_prefix_r == '0) && !lex_digit_r)
  `KIT_ASSERT_NEVER(a_pop_empty, out_xfer && (count_r == '0))

endmodule
